// File: rtl/trcu_pkg.sv
// ----------------------------------------------------------------------------
// trcu_pkg
// Shared widths, types and binomial tables for the triple rank/unrank block.
// ----------------------------------------------------------------------------
package trcu_pkg;

   localparam int ELEM_WIDTH = 6;
   localparam int RANK_WIDTH = 16;
   localparam int ELEM_COUNT = 1 << ELEM_WIDTH;

   localparam logic OP_RANK   = 1'b0;
   localparam logic OP_UNRANK = 1'b1;

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [RANK_WIDTH-1:0] rank_type;
   typedef logic [ELEM_COUNT-1:0][RANK_WIDTH-1:0] table_type;

   // Data that rides alongside the digit units down the pipeline.
   typedef struct packed {
      logic     op;
      logic     bad;
      elem_type elem_low;
      elem_type elem_mid;
      elem_type elem_high;
      rank_type rank;
   } side_type;

   // C(i,2) or C(i,3) for every element value, built at elaboration.
   function automatic table_type build_table(input int order);
      table_type t;
      int        v;
      for (int i = 0; i < ELEM_COUNT; i++) begin
         if (order == 3) begin
            v = i * (i - 1) * (i - 2) / 6;
         end else begin
            v = i * (i - 1) / 2;
         end
         t[i] = RANK_WIDTH'(v);
      end
      return t;
   endfunction

   localparam table_type CHOOSE2_TABLE = build_table(2);
   localparam table_type CHOOSE3_TABLE = build_table(3);

endpackage

// File: rtl/triple_combination_rank_unrank.sv
// ----------------------------------------------------------------------------
// triple_combination_rank_unrank
// Colex rank and unrank of 3-element subsets of 0..N-1.
// Throughput one request a cycle while busy is low.
// Four register stages: two per unranking digit (compare, then encode).
// busy is high only during reset and the cycle after it.
// Synchronous active-high reset clears the valid pipeline; no payload reset.
// The result cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module triple_combination_rank_unrank #(
   parameter int ELEMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  trcu_pkg::elem_type req_elem_low,
   input  trcu_pkg::elem_type req_elem_mid,
   input  trcu_pkg::elem_type req_elem_high,
   input  trcu_pkg::rank_type req_rank_in,
   output logic               rsp_strobe,
   output trcu_pkg::rank_type rsp_rank_out,
   output trcu_pkg::elem_type rsp_out_low,
   output trcu_pkg::elem_type rsp_out_mid,
   output trcu_pkg::elem_type rsp_out_high,
   output logic               rsp_bad_operand
);
   import trcu_pkg::*;

   localparam int NEFF = (ELEMENTS > ELEM_COUNT) ? ELEM_COUNT : ELEMENTS;
   localparam logic [RANK_WIDTH:0] RANK_LIMIT =
      (RANK_WIDTH + 1)'(NEFF * (NEFF - 1) * (NEFF - 2) / 6);
   localparam logic [ELEM_WIDTH:0] ELEM_LIMIT = (ELEM_WIDTH + 1)'(NEFF);

   logic                  busy_ff;
   logic [3:0]            valid_ff, valid_in;
   side_type              side1_ff, side1_in;
   side_type              side2_ff, side2_in;
   side_type              side3_ff;
   side_type              side4_ff;
   rank_type              c2_ff, c3_ff;
   elem_type              high_digit, high3_ff, high4_ff;
   elem_type              mid_digit;
   rank_type              rem_c, rem_b;
   logic                  accept;
   logic                  triple_ok;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= valid_in;
      end
   end

   assign valid_in = {valid_ff[2:0], accept};

   // Stage 1: operand checks and binomial lookups for the rank path.
   always_comb begin
      triple_ok = (req_elem_low < req_elem_mid) && (req_elem_mid < req_elem_high)
                  && ({1'b0, req_elem_high} < ELEM_LIMIT);
      side1_in.op        = req_op;
      side1_in.elem_low  = req_elem_low;
      side1_in.elem_mid  = req_elem_mid;
      side1_in.elem_high = req_elem_high;
      side1_in.rank      = req_rank_in;
      if (req_op == OP_UNRANK) begin
         side1_in.bad = ({1'b0, req_rank_in} >= RANK_LIMIT);
      end else begin
         side1_in.bad = !triple_ok;
      end
   end

   // Stage 2: rank sum.
   always_comb begin
      side2_in = side1_ff;
      if (side1_ff.op == OP_RANK) begin
         if (side1_ff.bad) begin
            side2_in.rank = '0;
         end else begin
            side2_in.rank = RANK_WIDTH'(side1_ff.elem_low) + c2_ff + c3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      c2_ff    <= CHOOSE2_TABLE[req_elem_mid];
      c3_ff    <= CHOOSE3_TABLE[req_elem_high];
      side2_ff <= side2_in;
      side3_ff <= side2_ff;
      side4_ff <= side3_ff;
      high3_ff <= high_digit;
      high4_ff <= high3_ff;
   end

   trcu_digit #(
      .THRESH (CHOOSE3_TABLE)
   ) u_digit_high (
      .clock     (clock),
      .value     (req_rank_in),
      .digit     (high_digit),
      .remainder (rem_c)
   );

   trcu_digit #(
      .THRESH (CHOOSE2_TABLE)
   ) u_digit_mid (
      .clock     (clock),
      .value     (rem_c),
      .digit     (mid_digit),
      .remainder (rem_b)
   );

   // Output select after stage 4.
   always_comb begin
      rsp_rank_out    = side4_ff.rank;
      rsp_out_low     = side4_ff.elem_low;
      rsp_out_mid     = side4_ff.elem_mid;
      rsp_out_high    = side4_ff.elem_high;
      rsp_bad_operand = side4_ff.bad;
      if (side4_ff.op == OP_UNRANK) begin
         if (side4_ff.bad) begin
            rsp_rank_out = '0;
            rsp_out_low  = '0;
            rsp_out_mid  = '0;
            rsp_out_high = '0;
         end else begin
            rsp_out_low  = rem_b[ELEM_WIDTH-1:0];
            rsp_out_mid  = mid_digit;
            rsp_out_high = high4_ff;
         end
      end
   end

   assign rsp_strobe = valid_ff[3];
   assign busy       = busy_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("request did not produce a result four cycles later");

   a_bad_rank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bad_operand) |-> (rsp_rank_out == '0))
      else $error("bad operand result carries a nonzero rank");

   a_triple_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_bad_operand) |->
         ((rsp_out_low < rsp_out_mid) && (rsp_out_mid < rsp_out_high)))
      else $error("good result triple not strictly increasing");

endmodule

// File: rtl/trcu_digit.sv
// ----------------------------------------------------------------------------
// trcu_digit
// Two-stage digit extraction: compare against every binomial threshold, then
// pick the largest index that fits and subtract its threshold.
// ----------------------------------------------------------------------------
module trcu_digit #(
   parameter trcu_pkg::table_type THRESH = trcu_pkg::CHOOSE3_TABLE
) (
   input  logic               clock,
   input  trcu_pkg::rank_type value,
   output trcu_pkg::elem_type digit,
   output trcu_pkg::rank_type remainder
);
   import trcu_pkg::*;

   logic [ELEM_COUNT-1:0] therm_ff, therm_in;
   rank_type              value_ff;
   elem_type              digit_ff, digit_in;
   rank_type              rem_ff, rem_in;

   // Thresholds rise with the index, so this is a thermometer code.
   always_comb begin
      for (int k = 0; k < ELEM_COUNT; k++) begin
         therm_in[k] = (THRESH[k] <= value);
      end
   end

   always_comb begin
      logic [ELEM_COUNT-1:0] top_bit;
      rank_type              sel;
      top_bit  = therm_ff & ~(therm_ff >> 1);
      sel      = '0;
      digit_in = '0;
      for (int k = 0; k < ELEM_COUNT; k++) begin
         if (top_bit[k]) begin
            digit_in = ELEM_WIDTH'(k);
         end
         sel = sel | (THRESH[k] & {RANK_WIDTH{top_bit[k]}});
      end
      rem_in = value_ff - sel;
   end

   always_ff @(posedge clock) begin
      therm_ff <= therm_in;
      value_ff <= value;
      digit_ff <= digit_in;
      rem_ff   <= rem_in;
   end

   assign digit     = digit_ff;
   assign remainder = rem_ff;

endmodule
